[sv/seir_pkg.sv]
package seir_pkg;

    localparam int GRID_SIDE_DEF = 64;

    localparam logic [2:0] REG_SIDE  = 3'd0;
    localparam logic [2:0] REG_EXP   = 3'd1;
    localparam logic [2:0] REG_INF   = 3'd2;
    localparam logic [2:0] REG_CATCH = 3'd3;
    localparam logic [2:0] REG_DEATH = 3'd4;
    localparam logic [2:0] REG_SEED  = 3'd5;

    localparam logic signed [7:0] CODE_DEAD  = -8'sd1;
    localparam logic signed [7:0] CODE_RECOV = -8'sd2;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_ADVANCE = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [5:0]        row;
        logic [5:0]        col;
        logic signed [7:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [7:0] read_value;
        logic [12:0]       live_count;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_HR, ST_HRW, ST_CPY, ST_CPYL, ST_SRD, ST_SEV,
        ST_NRD, ST_NEV, ST_DTH, ST_BK, ST_BKL, ST_FIN
    } state_t;

    function automatic logic is_exposed(input logic signed [7:0] c, input logic [5:0] e);
        return (c > 8'sd0) && ($signed({2'b00, c[6:0]}) <= $signed({3'b000, e})) && !c[7];
    endfunction

    function automatic logic is_infectious(input logic signed [7:0] c, input logic [5:0] e,
                                           input logic [5:0] i);
        logic [6:0] top;
        top = {1'b0, e} + {1'b0, i};
        return !c[7] && (c[6:0] > {1'b0, e}) && (c[6:0] <= top);
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

[sv/seir_grid_epidemic_step_core.sv]
// Stochastic SEIRD grid engine.
// Request channel (req_valid / req_stall, payload req): one beat is one action:
// write a cell, read a cell, or advance the whole grid one generation.
// Response channel (rsp_valid / rsp_stall, payload rsp): exactly one beat per
// request, in order. A read returns the cell code, an advance returns the count
// of exposed plus infectious cells (saturating at 8191); other fields are zero.
// An advance copies the grid into the working grid and back, visits every
// simulated cell and, for each infectious cell, its neighborhood; the shared
// grid memory ports and the single random draw/compare unit pace it.
// req_stall stays high while an action is in progress, so one action runs at
// a time. The response sits in an output register; the next request is taken
// while it waits, and a finished result holds until the receiver drops
// rsp_stall.
// Reset clears the registers to their defaults and then runs a clearing pass
// over the cell store, with req_stall high. The APB port (pready always high)
// stays usable throughout.
module seir_grid_epidemic_step_core
    import seir_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp
);

    localparam int IW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int AW = 2 * IW;
    localparam int NW = $clog2(GRID_SIDE + 1);

    // configuration registers
    logic [6:0]  side_reg;
    logic [5:0]  exp_reg;
    logic [5:0]  inf_reg;
    logic [16:0] catch_reg;
    logic [16:0] death_reg;
    logic [31:0] seed_reg;
    logic [31:0] rng_reg, rng_next;

    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    state_t state_reg, state_next;
    logic [AW-1:0] a_reg, a_next;     // sweep address
    logic [AW-1:0] wa_reg, wa_next;   // pending copy write address
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] r_reg, r_next, k_reg, k_next;
    logic [IW-1:0] hr_reg, hr_next;
    logic signed [7:0] c_reg, c_next;
    logic [12:0] cnt_reg, cnt_next;
    rsp_t res_reg, res_next;
    rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    // memory ports
    logic          cur_we, nxt_we;
    logic [AW-1:0] cur_wa, cur_ra, nxt_wa, nxt_ra;
    logic [7:0]    cur_wd, cur_rd, nxt_wd, nxt_rd;

    seir_ram #(.AW(AW), .DW(8)) u_cur
    (
        .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
        .raddr(cur_ra), .rdata(cur_rd)
    );

    seir_ram #(.AW(AW), .DW(8)) u_nxt
    (
        .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(nxt_ra), .rdata(nxt_rd)
    );

    // active side, clamped into 1..GRID_SIDE
    logic [NW-1:0] n_side, nm1;
    always_comb
    begin
        if (side_reg == 7'd0)
        begin
            n_side = NW'(1);
        end
        else if (int'(side_reg) > GRID_SIDE)
        begin
            n_side = NW'(GRID_SIDE);
        end
        else
        begin
            n_side = NW'(side_reg);
        end
        nm1 = n_side - NW'(1);
    end

    // neighborhood bounds around (i, j)
    logic [IW-1:0] r0, r1, c0, c1;
    always_comb
    begin
        r0 = (i_reg != '0) ? i_reg - IW'(1) : '0;
        c0 = (j_reg != '0) ? j_reg - IW'(1) : '0;
        r1 = ((NW'(i_reg) + NW'(1)) < n_side) ? i_reg + IW'(1) : IW'(nm1);
        c1 = ((NW'(j_reg) + NW'(1)) < n_side) ? j_reg + IW'(1) : IW'(nm1);
    end

    // shared draw unit: one generator step and one threshold compare
    logic [31:0] draw;
    logic [16:0] thr;
    logic        hit;
    assign draw = xorshift(rng_reg);
    assign thr  = (state_reg == ST_DTH) ? death_reg : catch_reg;
    assign hit  = {1'b0, draw[15:0]} < thr;

    logic signed [7:0] c_inc;
    assign c_inc = c_reg + 8'sd1;

    logic in_store;
    assign in_store = (int'(req.row) < GRID_SIDE) && (int'(req.col) < GRID_SIDE);

    logic cell_last;
    assign cell_last = (NW'(j_reg) == nm1) && (NW'(i_reg) == nm1);

    logic bk_in;
    assign bk_in = (NW'(wa_reg[AW-1:IW]) < n_side) && (NW'(wa_reg[IW-1:0]) < n_side);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= 7'd64;
            exp_reg   <= 6'd2;
            inf_reg   <= 6'd3;
            catch_reg <= 17'd32768;
            death_reg <= 17'd16384;
            seed_reg  <= 32'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_SIDE:  side_reg  <= pwdata[6:0];
                REG_EXP:   exp_reg   <= pwdata[5:0];
                REG_INF:   inf_reg   <= pwdata[5:0];
                REG_CATCH: catch_reg <= pwdata[16:0];
                REG_DEATH: death_reg <= pwdata[16:0];
                REG_SEED:  seed_reg  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SIDE:  prdata = {25'd0, side_reg};
            REG_EXP:   prdata = {26'd0, exp_reg};
            REG_INF:   prdata = {26'd0, inf_reg};
            REG_CATCH: prdata = {15'd0, catch_reg};
            REG_DEATH: prdata = {15'd0, death_reg};
            REG_SEED:  prdata = seed_reg;
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            a_reg         <= '0;
            out_valid_reg <= 1'b0;
            rng_reg       <= 32'd1;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && paddr[4:2] == REG_SEED)
            begin
                rng_reg <= (pwdata != 32'd0) ? pwdata : 32'd1;
            end
            else
            begin
                rng_reg <= rng_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg  <= wa_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        r_reg   <= r_next;
        k_reg   <= k_next;
        hr_reg  <= hr_next;
        c_reg   <= c_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        wa_next    = wa_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        hr_next    = hr_reg;
        c_next     = c_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        rng_next   = rng_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        cur_we = 1'b0;
        cur_wa = a_reg;
        cur_wd = 8'd0;
        cur_ra = a_reg;
        nxt_we = 1'b0;
        nxt_wa = wa_reg;
        nxt_wd = cur_rd;
        nxt_ra = a_reg;

        unique case (state_reg)
            ST_CLR:
            begin
                cur_we = 1'b1;
                a_next = a_reg + AW'(1);
                if (a_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_next = '0;
                    state_next = ST_FIN;
                    unique case (req.action)
                        ACT_WRITE:
                        begin
                            cur_we = in_store;
                            cur_wa = {IW'(req.row), IW'(req.col)};
                            cur_wd = req.write_value;
                        end
                        ACT_READ:
                        begin
                            if (in_store)
                            begin
                                hr_next = IW'(req.row);
                                j_next  = IW'(req.col);
                                state_next = ST_HR;
                            end
                        end
                        ACT_ADVANCE:
                        begin
                            a_next  = '0;
                            state_next = ST_CPY;
                        end
                        default: ;
                    endcase
                end
            end
            ST_HR:
            begin
                cur_ra = {hr_reg, j_reg};
                state_next = ST_HRW;
            end
            ST_HRW:
            begin
                res_next.read_value = cur_rd;
                state_next = ST_FIN;
            end
            ST_CPY:
            begin
                // copy the current grid into the working grid; the write address trails the read address through wa_reg
                nxt_we  = (a_reg != '0);
                wa_next = a_reg;
                a_next  = a_reg + AW'(1);
                if (a_reg == '1)
                begin
                    state_next = ST_CPYL;
                end
            end
            ST_CPYL:
            begin
                nxt_we = 1'b1;
                i_next = '0;
                j_next = '0;
                state_next = ST_SRD;
            end
            ST_SRD:
            begin
                cur_ra = {i_reg, j_reg};
                state_next = ST_SEV;
            end
            ST_SEV, ST_DTH:
            begin
                logic adv;
                adv = 1'b0;
                nxt_wa = {i_reg, j_reg};
                if (state_reg == ST_SEV)
                begin
                    c_next = cur_rd;
                    if (is_exposed(cur_rd, exp_reg))
                    begin
                        nxt_we = 1'b1;
                        nxt_wd = cur_rd + 8'd1;
                        adv = 1'b1;
                    end
                    else if (is_infectious(cur_rd, exp_reg, inf_reg))
                    begin
                        nxt_we = 1'b1;
                        nxt_wd = cur_rd + 8'd1;
                        r_next = r0;
                        k_next = c0;
                        state_next = ST_NRD;
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
                else
                begin
                    // end of infection: one draw for death or recovery
                    if (!is_infectious(c_inc, exp_reg, inf_reg))
                    begin
                        rng_next = draw;
                        nxt_we = 1'b1;
                        nxt_wd = hit ? CODE_DEAD : CODE_RECOV;
                    end
                    adv = 1'b1;
                end
                if (adv)
                begin
                    if (cell_last)
                    begin
                        a_next = '0;
                        cnt_next = '0;
                        state_next = ST_BK;
                    end
                    else
                    begin
                        state_next = ST_SRD;
                        if (NW'(j_reg) == nm1)
                        begin
                            j_next = '0;
                            i_next = i_reg + IW'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IW'(1);
                        end
                    end
                end
            end
            ST_NRD:
            begin
                nxt_ra = {r_reg, k_reg};
                state_next = ST_NEV;
            end
            ST_NEV:
            begin
                nxt_wa = {r_reg, k_reg};
                nxt_wd = 8'd1;
                if (nxt_rd == 8'd0)
                begin
                    rng_next = draw;
                    nxt_we = hit;
                end
                state_next = ST_NRD;
                if (k_reg == c1)
                begin
                    k_next = c0;
                    r_next = r_reg + IW'(1);
                    if (r_reg == r1)
                    begin
                        state_next = ST_DTH;
                    end
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_BK, ST_BKL:
            begin
                // copy back and count live cells inside the active square
                cur_wa = wa_reg;
                cur_wd = nxt_rd;
                if (state_reg == ST_BKL || a_reg != '0)
                begin
                    cur_we = 1'b1;
                    if (bk_in && cnt_reg != '1 &&
                        (is_exposed(nxt_rd, exp_reg) ||
                         is_infectious(nxt_rd, exp_reg, inf_reg)))
                    begin
                        cnt_next = cnt_reg + 13'd1;
                    end
                end
                if (state_reg == ST_BK)
                begin
                    wa_next = a_reg;
                    a_next  = a_reg + AW'(1);
                    if (a_reg == '1)
                    begin
                        state_next = ST_BKL;
                    end
                end
                else
                begin
                    res_next = '0;
                    res_next.live_count = cnt_next;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_rng_nonzero: assert property (@(posedge clk) disable iff (!rst_n) rng_reg != 32'd0)
        else $error("generator state went to zero");
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRD || state_reg == ST_NRD) |->
            (NW'(i_reg) < n_side && NW'(j_reg) < n_side))
        else $error("scan position outside active square");
    a_nb_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NRD |-> (r_reg >= r0 && r_reg <= r1 && k_reg >= c0 && k_reg <= c1))
        else $error("neighbor outside neighborhood");
    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule

[sv/seir_ram.sv]
module seir_ram
#(
    parameter int AW = 12,
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
